// ===== rtl/core/range_max_constraint_fill_unit_defines.svh =====
// assertion macros used by the asserting file of the fill unit
`ifndef RANGE_MAX_CONSTRAINT_FILL_UNIT_DEFINES_SVH
`define RANGE_MAX_CONSTRAINT_FILL_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define RMCF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define RMCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rmcf_pkg.sv =====
package rmcf_pkg;

	localparam int CELLS_DEF = 1024;
	localparam int CFG_W     = 11;
	localparam int IDX_W     = 10;
	localparam int VAL_W     = 32;
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
	localparam logic [VAL_W-1:0] UNCOVERED = 32'h7FFF_FFFF;

	localparam logic MODE_CONSTRAIN = 1'b0;
	localparam logic MODE_READ      = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_RESP
	} rmcf_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clr_step;
		logic scan_step;
		logic read_issue;
		logic resp_load;
	} rmcf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic scan_last;
		logic item_empty;
		logic out_free;
	} rmcf_sts_t;

endpackage

// ===== rtl/core/rmcf_ram.sv =====
module rmcf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/rmcf_ctrl.sv =====
module rmcf_ctrl
	import rmcf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_mode,
	output logic        in_ready,
	input  rmcf_sts_t   sts,
	output rmcf_cmd_t   cmd
);

	rmcf_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (in_mode == MODE_READ) begin
						state_d = ST_READ;
					end else if (!sts.item_empty) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (sts.scan_last) state_d = ST_IDLE;
			end
			ST_READ: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN: cmd.scan_step = 1'b1;
			ST_READ: cmd.read_issue = 1'b1;
			ST_RESP: cmd.resp_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/core/rmcf_dp.sv =====
module rmcf_dp
	import rmcf_pkg::*;
#(
	parameter int CELLS = CELLS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic [IDX_W-1:0] in_left,
	input  logic [IDX_W-1:0] in_right,
	input  logic [VAL_W-1:0] in_val,
	input  rmcf_cmd_t        cmd,
	output rmcf_sts_t        sts,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [VAL_W-1:0] out_value,
	output logic             out_covered
);

	localparam int AW   = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CNTW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

	logic [CFG_W-1:0] cell_count_q;
	logic [CNTW-1:0]  cnt_ext, used, left_ext, right_ext, right_clip;
	logic [CNTW-1:0]  cur_q, end_q;
	logic [VAL_W-1:0] val_q;
	logic             in_range_q;
	logic [AW-1:0]    clr_q;
	logic             scan_v_s1;
	logic [AW-1:0]    addr_s1;
	logic [VAL_W-1:0] val_rd;
	logic [0:0]       flag_rd;
	logic             upd;
	logic             val_we, flag_we;
	logic [AW-1:0]    flag_waddr;
	logic             out_valid_q, out_cov_q;
	logic [VAL_W-1:0] out_val_q;

	// config register, taken on every transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_count_q <= CFG_RESET;
		end else if (cfg_valid) begin
			cell_count_q <= cfg_data;
		end
	end

	assign cnt_ext    = CNTW'(cell_count_q);
	assign used       = (cnt_ext > CNTW'(CELLS)) ? CNTW'(CELLS) : cnt_ext;
	assign left_ext   = CNTW'(in_left);
	assign right_ext  = CNTW'(in_right);
	assign right_clip = (right_ext >= used) ? used - CNTW'(1) : right_ext;

	assign sts.item_empty = (left_ext > right_ext) || (left_ext >= used);
	assign sts.scan_last  = (cur_q == end_q);
	assign sts.clr_last   = (clr_q == AW'(CELLS - 1));
	assign sts.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q      <= left_ext;
			end_q      <= right_clip;
			val_q      <= in_val;
			in_range_q <= (left_ext < used);
		end else if (cmd.scan_step) begin
			cur_q <= cur_q + CNTW'(1);
		end
		if (cmd.scan_step) begin
			addr_s1 <= cur_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			scan_v_s1 <= 1'b0;
		end else begin
			scan_v_s1 <= cmd.scan_step;
			if (cmd.clr_step) clr_q <= clr_q + AW'(1);
		end
	end

	// keep the larger value, or take it if the cell was never covered
	assign upd        = !flag_rd[0] || ($signed(val_q) > $signed(val_rd));
	assign val_we     = scan_v_s1 && upd;
	assign flag_we    = cmd.clr_step || val_we;
	assign flag_waddr = cmd.clr_step ? clr_q : addr_s1;

	rmcf_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CELLS)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (addr_s1),
		.wdata (val_q),
		.re    (cmd.scan_step || cmd.read_issue),
		.raddr (cur_q[AW-1:0]),
		.rdata (val_rd)
	);

	rmcf_ram #(
		.WIDTH (1),
		.DEPTH (CELLS)
	) u_flag_ram (
		.clk   (clk),
		.we    (flag_we),
		.waddr (flag_waddr),
		.wdata (!cmd.clr_step),
		.re    (cmd.scan_step || cmd.read_issue),
		.raddr (cur_q[AW-1:0]),
		.rdata (flag_rd)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.resp_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp_load) begin
			out_cov_q <= in_range_q && flag_rd[0];
			out_val_q <= (in_range_q && flag_rd[0]) ? val_rd : UNCOVERED;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_value   = out_val_q;
	assign out_covered = out_cov_q;

endmodule

// ===== rtl/core/range_max_constraint_fill_unit.sv =====
// Range max constraint fill unit. Keeps an array of CELLS signed 32-bit cells
// and a covered flag per cell. A constraint item (tuser 0) raises every cell
// of [range_left, range_right], clipped to cell_count, to at least
// bound_value and marks it covered; it gives no result. A read item (tuser 1)
// returns the cell at range_left with its flag, or 2147483647 with flag 0
// when the cell is uncovered or at or beyond cell_count. A constraint is
// accepted and then scans the cells of its clipped range in order, an empty
// or reversed range is only accepted, and a read is accepted, then issued,
// then waits for the result slot to take its result. The scan pace is
// set by the single read port and single write port of the cell memories:
// each cell is one read, one compare and one write, pipelined one per cycle.
// After reset the covered flags are cleared by a pass over all CELLS cells
// during which no item is taken; cell_count writes are taken at any time.
`include "range_max_constraint_fill_unit_defines.svh"

module range_max_constraint_fill_unit
	import rmcf_pkg::*;
#(
	parameter int CELLS = CELLS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// config write: cell_count
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_data,
	// item input
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // range_left, range_right, bound_value, zero pad
	input  logic [0:0]           s_tuser,  // mode
	// result output
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // cell_result
	output logic [0:0]           m_tuser   // cell_covered
);

	rmcf_cmd_t        cmd;
	rmcf_sts_t        sts;
	logic [IDX_W-1:0] in_left, in_right;
	logic [VAL_W-1:0] in_val;

	// the register takes a write in any cycle
	assign cfg_ready = 1'b1;

	// unpack the input transfer
	assign in_left  = s_tdata[IDX_W-1:0];
	assign in_right = s_tdata[2*IDX_W-1:IDX_W];
	assign in_val   = s_tdata[2*IDX_W+VAL_W-1:2*IDX_W];

	// sequencer: clear pass, idle, range scan, read, result hand-off
	rmcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_mode  (s_tuser[0]),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// cell memories, compare and update, output register
	rmcf_dp #(
		.CELLS (CELLS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.in_left     (in_left),
		.in_right    (in_right),
		.in_val      (in_val),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_value   (m_tdata),
		.out_covered (m_tuser[0])
	);

	// no item is taken while the flags are being cleared
	`RMCF_ASSERT_NOW(a_no_take_in_clear, cmd.clr_step, !s_tready, "item taken during clear")
	// the memory is driven by one sequencer step at a time
	`RMCF_ASSERT_NOW(a_one_step, 1'b1, $onehot0({cmd.clr_step, cmd.scan_step, cmd.read_issue}),
		"sequencer steps overlap")
	// a read transfer blocks the input until its result is loaded into the output register
	`RMCF_ASSERT_NEXT(a_read_blocks, s_tvalid && s_tready && (s_tuser[0] == MODE_READ),
		!s_tready, "input open during read")
	// an uncovered result always carries the fill value
	`RMCF_ASSERT_NOW(a_uncovered_value, m_tvalid && !m_tuser[0], m_tdata == UNCOVERED,
		"uncovered cell with wrong value")

endmodule

// ===== verif/range_max_constraint_fill_unit_tb.sv =====
module range_max_constraint_fill_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rmcf_pkg::*;

	// longest item is a full-array constraint: an accept plus a scan of 1024 cells
	localparam int SETTLE_CYCLES = 1100;

	// one expected read result
	typedef struct {
		logic [VAL_W-1:0] value;
		logic             covered;
	} cell_read_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0; // range_left, range_right, bound_value, zero pad
	logic [0:0]           s_tuser   = MODE_CONSTRAIN; // mode
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;  // cell_result
	logic [0:0]           m_tuser;  // cell_covered

	// shadow copy of the cell array, flags and cell_count
	logic [VAL_W-1:0] cell_value_model [CELLS_DEF];
	bit               cell_flag_model  [CELLS_DEF];
	logic [CFG_W-1:0] count_model = CFG_RESET;

	// reads accepted but not yet answered, oldest first
	cell_read_t pending_reads [$];
	cell_read_t exp_read;

	// flow control knobs, in percent
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// bookkeeping for the summary
	int n_fail        = 0;
	int n_constraints = 0;
	int n_reads       = 0;
	int n_cfg_writes  = 0;
	int n_checked     = 0;
	int n_hits        = 0;

	range_max_constraint_fill_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// hard stop in case a handshake never completes
	initial begin
		#30_000_000;
		$display("simulation failed");
		$finish;
	end

	// register above the array size counts as the whole array
	function automatic int cells_used();
		return (int'(count_model) > CELLS_DEF) ? CELLS_DEF : int'(count_model);
	endfunction

	// max-update of every in-use cell of [lo, hi], marking each covered
	function automatic void paint_range(input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi,
			input logic [VAL_W-1:0] bound);
		int last;
		last = cells_used() - 1;
		if (lo > hi || last < 0)
			return;
		if (int'(hi) < last)
			last = int'(hi);
		for (int j = int'(lo); j <= last; j++) begin
			if (!cell_flag_model[j] || $signed(bound) > $signed(cell_value_model[j])) begin
				cell_value_model[j] = bound;
				cell_flag_model[j]  = 1'b1;
			end
		end
	endfunction

	// what a read of one cell returns right now
	function automatic cell_read_t expected_cell(input logic [IDX_W-1:0] idx);
		cell_read_t r;
		if (int'(idx) < cells_used() && cell_flag_model[idx]) begin
			r.value   = cell_value_model[idx];
			r.covered = 1'b1;
		end else begin
			r.value   = UNCOVERED;
			r.covered = 1'b0;
		end
		return r;
	endfunction

	// result side: compare each transfer with the oldest pending read, then pick the next ready
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reads.size() == 0) begin
				$display("%0t: unexpected result, cell_result %h cell_covered %b",
					$time, m_tdata, m_tuser);
				n_fail++;
			end else begin
				exp_read = pending_reads.pop_front();
				n_checked++;
				if (exp_read.covered)
					n_hits++;
				if (m_tdata !== exp_read.value) begin
					$display("%0t: cell_result mismatch, expected %h actual %h",
						$time, exp_read.value, m_tdata);
					n_fail++;
				end
				if (m_tuser[0] !== exp_read.covered) begin
					$display("%0t: cell_covered mismatch, expected %b actual %b",
						$time, exp_read.covered, m_tuser[0]);
					n_fail++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic set_flow(input int idle_pct, input int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
	endtask

	// one item transfer; valid stays high into the next call unless a gap is taken
	task automatic send_item(input logic mode, input logic [IDX_W-1:0] left,
			input logic [IDX_W-1:0] right, input logic [VAL_W-1:0] bound);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {4'b0, bound, right, left};
		do @(posedge clk); while (!s_tready);
		// accepted: update the shadow state in acceptance order
		if (mode == MODE_READ) begin
			pending_reads.push_back(expected_cell(left));
			n_reads++;
		end else begin
			paint_range(left, right, bound);
			n_constraints++;
		end
	endtask

	// stop sending, wait for every read answer, then let a trailing constraint finish
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called with the block idle
	task automatic write_cell_count(input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		count_model = value;
		n_cfg_writes++;
	endtask

	// both ends of the array read back uncovered after reset
	task automatic test_reset_state();
		send_item(MODE_READ, 10'd0, 10'd0, '0);
		send_item(MODE_READ, 10'd1023, 10'd0, '0);
	endtask

	// value and index extremes, overlapping ranges, equal values, reversed range
	task automatic test_field_extremes();
		send_item(MODE_CONSTRAIN, 10'd0, 10'd1023, 32'h8000_0000);
		send_item(MODE_READ, 10'd512, 10'd0, '0);
		send_item(MODE_CONSTRAIN, 10'd1023, 10'd1023, 32'h7FFF_FFFF);
		send_item(MODE_READ, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
		// lower value must not overwrite the overlap
		send_item(MODE_CONSTRAIN, 10'd100, 10'd200, 32'd5);
		send_item(MODE_CONSTRAIN, 10'd150, 10'd250, 32'd3);
		send_item(MODE_READ, 10'd150, 10'd0, '0);
		send_item(MODE_READ, 10'd250, 10'd0, '0);
		// equal value twice on one cell
		send_item(MODE_CONSTRAIN, 10'd300, 10'd300, 32'hFFFF_FFFF);
		send_item(MODE_CONSTRAIN, 10'd300, 10'd300, 32'hFFFF_FFFF);
		send_item(MODE_READ, 10'd300, 10'd0, '0);
		// reversed range leaves the array untouched
		send_item(MODE_CONSTRAIN, 10'd600, 10'd400, 32'd99);
		send_item(MODE_READ, 10'd500, 10'd0, '0);
	endtask

	// zero cells, oversize register, range and read past the end, shrink then grow
	task automatic test_cell_count_settings();
		drain_results();
		write_cell_count(11'd0);
		send_item(MODE_CONSTRAIN, 10'd0, 10'd10, 32'd77);
		send_item(MODE_READ, 10'd0, 10'd0, '0);
		drain_results();
		write_cell_count(11'd2047);
		send_item(MODE_READ, 10'd1023, 10'd0, '0);
		drain_results();
		write_cell_count(11'd8);
		send_item(MODE_CONSTRAIN, 10'd5, 10'd900, 32'd1000);
		send_item(MODE_READ, 10'd7, 10'd0, '0);
		send_item(MODE_READ, 10'd8, 10'd0, '0);
		drain_results();
		// hidden cells come back with their old contents
		write_cell_count(11'd1024);
		send_item(MODE_READ, 10'd8, 10'd0, '0);
		send_item(MODE_READ, 10'd6, 10'd0, '0);
	endtask

	// random mix under one cell_count; reads lean toward the last painted range
	task automatic test_random_traffic(input int n_items, input logic [CFG_W-1:0] count);
		int               span;
		int               roll;
		int               hi;
		int               hist_lo;
		int               hist_hi;
		bit               hist_ok;
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic [VAL_W-1:0] bound;
		hist_ok = 1'b0;
		hist_lo = 0;
		hist_hi = 0;
		drain_results();
		write_cell_count(count);
		span = (cells_used() == 0) ? 1 : cells_used();
		for (int k = 0; k < n_items; k++) begin
			roll  = $urandom_range(99);
			right = 10'($urandom);
			bound = $urandom;
			if (roll < 40) begin
				roll = $urandom_range(99);
				if (roll < 50 && hist_ok)
					left = 10'($urandom_range(hist_hi, hist_lo));
				else if (roll < 85)
					left = 10'($urandom_range((span + 3 > 1023) ? 1023 : span + 3));
				else
					left = 10'($urandom);
				send_item(MODE_READ, left, right, bound);
			end else begin
				roll = $urandom_range(99);
				if (roll < 75) begin
					left = 10'($urandom_range(span - 1));
					hi   = int'(left) + $urandom_range(15);
					right = 10'((hi > 1023) ? 1023 : hi);
				end else if (roll < 82) begin
					// rare whole-array sweep
					left  = 10'($urandom_range(3));
					right = 10'd1023;
				end else if (roll < 92) begin
					left  = 10'($urandom_range(1023, 1));
					right = 10'($urandom_range(int'(left) - 1, 0));
				end else begin
					left = 10'($urandom);
				end
				roll = $urandom_range(99);
				if (roll < 30)
					bound = 32'($urandom_range(40)) - 32'd20;
				else if (roll < 40)
					bound = 32'h8000_0000;
				else if (roll < 50)
					bound = 32'h7FFF_FFFF;
				if (left <= right) begin
					hist_lo = int'(left);
					hist_hi = int'(right);
					hist_ok = 1'b1;
				end
				send_item(MODE_CONSTRAIN, left, right, bound);
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// sender rarely idles, receiver mostly stalls
		set_flow(10, 70);
		test_reset_state();
		test_field_extremes();
		test_cell_count_settings();
		test_random_traffic(93, 11'd1024);
		test_random_traffic(93, 11'd37);

		// sender mostly idles, receiver rarely stalls
		set_flow(70, 10);
		test_random_traffic(93, 11'd1);
		test_random_traffic(93, 11'd2047);

		// full rate both sides
		set_flow(0, 0);
		test_random_traffic(93, 11'd513);
		test_random_traffic(93, 11'd1024);

		drain_results();
		$display("sent %0d constraint transfers and %0d read transfers across %0d cell_count writes",
			n_constraints, n_reads, n_cfg_writes);
		$display("checked %0d results, %0d from covered cells, %0d mismatches",
			n_checked, n_hits, n_fail);
		if (n_fail == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/rmcf_pkg.sv
rtl/core/rmcf_ram.sv
rtl/core/rmcf_ctrl.sv
rtl/core/rmcf_dp.sv
rtl/core/range_max_constraint_fill_unit.sv
verif/range_max_constraint_fill_unit_tb.sv
